// ===== rtl/inertia_telemetry_framer_defines.svh =====
// Assertion macros for the telemetry framer checker.
// No dependencies; included by the checker file.
`ifndef INERTIA_TELEMETRY_FRAMER_DEFINES_SVH
`define INERTIA_TELEMETRY_FRAMER_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define ITF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ITF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/itf_pkg.sv =====
// Shared types, constants and helper functions of the telemetry framer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package itf_pkg;

	localparam int FRAME_BYTES    = 32;
	localparam int TIME_BITS_DEF  = 32;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int ADDR_W         = 5;
	localparam int DIV_NUM_W      = 48;
	localparam int DIV_DEN_W      = 42;

	localparam logic [2:0] REG_INTERVAL = 3'd0;
	localparam logic [2:0] REG_TIMEOUT  = 3'd1;
	localparam logic [2:0] REG_COMP1    = 3'd2;
	localparam logic [2:0] REG_COMP2    = 3'd3;
	localparam logic [2:0] REG_IDLE     = 3'd4;

	localparam logic [15:0] INTERVAL_RST = 16'd20;
	localparam logic [15:0] TIMEOUT_RST  = 16'd100;
	localparam logic [7:0]  COMP1_RST    = 8'd4;
	localparam logic [7:0]  COMP2_RST    = 8'd5;
	localparam logic [7:0]  IDLE_RST     = 8'd0;

	localparam logic [7:0]  SYNC0       = 8'hA5;
	localparam logic [7:0]  SYNC1       = 8'h5A;
	localparam logic [7:0]  VERSION     = 8'h01;
	localparam logic [7:0]  PAYLOAD_LEN = 8'd26;
	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;

	typedef struct packed {
		logic [31:0]        time_ms;
		logic [7:0]         task_id;
		logic [7:0]         motion_code;
		logic signed [31:0] distance_16th_mm;
		logic [31:0]        gyro_count;
		logic               gyro_ok;
		logic [47:0]        accel_xyz;
		logic [47:0]        attitude;
		logic signed [15:0] left_drive;
		logic signed [15:0] right_drive;
	} tick_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} frame_out_t;

	typedef struct packed {
		tick_t tick;
		logic  first;
	} q_entry_t;

	typedef struct packed {
		logic [15:0] interval;
		logic [15:0] timeout;
		logic [7:0]  comp1;
		logic [7:0]  comp2;
		logic [7:0]  idle;
	} cfg_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Apply sign to a rounded magnitude and clamp to int16.
	function automatic logic [15:0] round_sat16(input logic [DIV_NUM_W-1:0] q, input logic neg);
		if (!neg) begin
			return (q > DIV_NUM_W'(32767)) ? 16'h7FFF : q[15:0];
		end
		return (q > DIV_NUM_W'(32768)) ? 16'h8000 : (16'd0 - q[15:0]);
	endfunction

endpackage

// ===== rtl/itf_queue.sv =====
// Small FIFO of emitted ticks between the front and the back.
// Depends on itf_pkg for the entry type.
`timescale 1ns / 1ps
module itf_queue #(
	parameter int DEPTH = itf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  itf_pkg::q_entry_t push_entry,
	output logic             full,
	output logic             pop_valid,
	output itf_pkg::q_entry_t pop_entry,
	input  logic             pop
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	itf_pkg::q_entry_t slot_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_entry = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule

// ===== rtl/itf_front.sv =====
// Front end: accept ticks, drop those inside the transmit interval.
// Depends on itf_pkg; feeds itf_queue.
`timescale 1ns / 1ps
module itf_front #(
	parameter int TIME_BITS = itf_pkg::TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  itf_pkg::tick_t    in_item,
	input  logic [15:0]       interval,
	input  logic              q_full,
	output logic              push,
	output itf_pkg::q_entry_t push_entry
);
	logic                 primed_q;
	logic [TIME_BITS-1:0] last_send_q;
	logic [TIME_BITS-1:0] t, since;
	logic                 accept, emit;

	assign t        = in_item.time_ms[TIME_BITS-1:0];
	assign since    = t - last_send_q;
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	// first tick always goes out: emit is forced while the front is not yet primed
	assign emit     = !primed_q || (since >= TIME_BITS'(interval));
	assign push     = accept && emit;
	assign push_entry = '{tick: in_item, first: !primed_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q    <= 1'b0;
			last_send_q <= '0;
		end else if (push) begin
			primed_q    <= 1'b1;
			last_send_q <= t;
		end
	end
endmodule

// ===== rtl/itf_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on itf_pkg for the request and response types.
`timescale 1ns / 1ps
module itf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  itf_pkg::div_req_t req,
	output itf_pkg::div_rsp_t rsp
);
	localparam int NW = itf_pkg::DIV_NUM_W;
	localparam int DW = itf_pkg::DIV_DEN_W;
	localparam int CW = $clog2(NW + 1);

	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   shifted;
	logic          fits;

	assign shifted = {rem_q[DW-1:0], quo_q[NW-1]};
	assign fits    = (shifted >= {1'b0, den_q});
	assign rsp     = '{done: done_q, quo: quo_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= fits ? (shifted - {1'b0, den_q}) : shifted;
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= CW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== rtl/itf_back.sv =====
// Back end: speed filter, gyro check, drive fields, then byte serializer with CRC.
// Depends on itf_pkg and itf_div; takes ticks from itf_queue.
`timescale 1ns / 1ps
module itf_back #(
	parameter int TIME_BITS = itf_pkg::TIME_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  itf_pkg::cfg_t       cfg,
	input  logic                q_valid,
	input  itf_pkg::q_entry_t   q_entry,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output itf_pkg::frame_out_t out_item
);
	localparam int TB = TIME_BITS;
	localparam int NW = itf_pkg::DIV_NUM_W;
	localparam int DW = itf_pkg::DIV_DEN_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PREP, ST_MEAS_GO, ST_MEAS, ST_ACC_GO, ST_ACC,
		ST_RATE_GO, ST_RATE, ST_SEND
	} state_t;

	state_t state_q;

	// persistent state
	logic [7:0]         seq_q, last_task_q;
	logic [TB-1:0]      sst_q, gst_q;
	logic [31:0]        gcs_q;
	logic [31:0]        ld_q;
	logic [30:0]        smo_q;
	logic               est_q;
	logic [16:0]        lfd_q;

	// per-frame work registers
	itf_pkg::tick_t     tick_q;
	logic               first_q;
	logic [TB-1:0]      elapsed_q;
	logic [NW-1:0]      meas_num_q, rate_num_q;
	logic [16:0]        rate_den_q;
	logic               rate_neg_q, acc_neg_q;
	logic [30:0]        old_q;
	logic [15:0]        accel_q, rate_q, fwd_q, turn_q;
	logic [7:0]         flags_q;
	logic [15:0]        crc_q;
	logic [4:0]         idx_q;
	itf_pkg::frame_out_t out_q;
	logic               out_valid_q;

	itf_pkg::div_req_t  div_req;
	itf_pkg::div_rsp_t  div_rsp;

	itf_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// prep-stage signals
	logic [TB-1:0]      t, sst_p, gst_p, sst_e, gst_e, elapsed, gy_age;
	logic [7:0]         lt;
	logic [31:0]        dist_v, ld_p, ld_e, gcs_p;
	logic [30:0]        smo_p, smo_e;
	logic               est_p, est_e, rst_est, gyro_v, comp, moving;
	logic [16:0]        lfd_p;
	logic [32:0]        dd;
	logic [NW-1:0]      meas_n;
	logic signed [16:0] s, dt;
	logic [16:0]        a_s, a_t;
	logic signed [17:0] dr;
	logic signed [23:0] m;
	logic [23:0]        am;
	logic [15:0]        div_e;

	always_comb begin
		t      = tick_q.time_ms[TB-1:0];
		dist_v = tick_q.distance_16th_mm;
		lt     = first_q ? cfg.idle : last_task_q;
		ld_p   = first_q ? dist_v : ld_q;
		sst_p  = first_q ? t : sst_q;
		gst_p  = first_q ? t : gst_q;
		gcs_p  = first_q ? tick_q.gyro_count : gcs_q;
		smo_p  = first_q ? '0 : smo_q;
		est_p  = first_q ? 1'b0 : est_q;
		lfd_p  = first_q ? '0 : lfd_q;
		rst_est = (tick_q.task_id != lt) ||
			($signed({dist_v[31], dist_v}) + 33'sd80 < $signed({ld_p[31], ld_p}));
		ld_e   = rst_est ? dist_v : ld_p;
		sst_e  = rst_est ? t : sst_p;
		smo_e  = rst_est ? '0 : smo_p;
		est_e  = rst_est ? 1'b0 : est_p;
		elapsed = t - sst_e;
		dd     = {dist_v[31], dist_v} - {ld_e[31], ld_e};
		meas_n = (!dd[32] && dd != '0) ? NW'(dd[31:0]) * NW'(16000) : '0;
		gst_e  = (tick_q.gyro_count != gcs_p) ? t : gst_p;
		gy_age = t - gst_e;
		gyro_v = (gy_age <= TB'(cfg.timeout)) && tick_q.gyro_ok;
		comp   = (tick_q.task_id == cfg.comp1) || (tick_q.task_id == cfg.comp2);
		moving = (tick_q.left_drive > 16'sd10) || (tick_q.left_drive < -16'sd10) ||
			(tick_q.right_drive > 16'sd10) || (tick_q.right_drive < -16'sd10);
		s      = 17'(tick_q.left_drive) + 17'(tick_q.right_drive);
		dt     = 17'(tick_q.right_drive) - 17'(tick_q.left_drive);
		a_s    = s[16] ? 17'(-s) : 17'(s);
		a_t    = dt[16] ? 17'(-dt) : 17'(dt);
		dr     = 18'(s) - 18'($signed(lfd_p));
		m      = 24'(dr) * 24'sd50;
		am     = m[23] ? 24'(-m) : 24'(m);
		div_e  = (cfg.interval == '0) ? 16'd1 : cfg.interval;
	end

	// measurement and filter
	logic [NW-1:0] meas_sat;
	logic [39:0]   filt;
	logic [32:0]   sdiff;
	logic [31:0]   adiff;
	logic [NW-1:0] acc_num;

	always_comb begin
		meas_sat = (div_rsp.quo > NW'(32'h7FFF_FFFF)) ? NW'(32'h7FFF_FFFF) : div_rsp.quo;
		filt     = 40'(smo_q) * 40'd90 + 40'(meas_sat[30:0]) * 40'd166 + 40'd128;
		sdiff    = {2'b00, smo_q} - {2'b00, old_q};
		adiff    = sdiff[32] ? 32'(-sdiff) : sdiff[31:0];
		acc_num  = ((NW'(adiff) * NW'(1000)) << 1) + (NW'(elapsed_q) << 8);
	end

	always_comb begin
		div_req.start = (state_q == ST_MEAS_GO) || (state_q == ST_ACC_GO) ||
			(state_q == ST_RATE_GO);
		unique case (state_q)
			ST_ACC_GO: begin
				div_req.num = acc_num;
				div_req.den = DW'(elapsed_q) << 9;
			end
			ST_RATE_GO: begin
				div_req.num = rate_num_q;
				div_req.den = DW'(rate_den_q);
			end
			default: begin
				div_req.num = meas_num_q;
				div_req.den = DW'(elapsed_q);
			end
		endcase
	end

	// frame body, byte 0 in the low bits, CRC in the top two bytes
	logic [23:0]  sp;
	logic [15:0]  speed_f;
	logic [47:0]  acc_g, att_g;
	logic [255:0] body;
	logic [7:0]   cur_byte;
	logic         load;

	always_comb begin
		sp      = 24'((32'(smo_q) + 32'd128) >> 8);
		speed_f = (sp > 24'd32767) ? 16'h7FFF : sp[15:0];
		acc_g   = flags_q[0] ? tick_q.accel_xyz : '0;
		att_g   = flags_q[0] ? tick_q.attitude : '0;
		body    = {crc_q, rate_q, turn_q, fwd_q, accel_q, speed_f,
			att_g[47:32], att_g[31:16], att_g[15:0],
			acc_g[47:32], acc_g[31:16], acc_g[15:0],
			flags_q, tick_q.motion_code, tick_q.task_id, seq_q,
			itf_pkg::PAYLOAD_LEN, itf_pkg::VERSION, itf_pkg::SYNC1, itf_pkg::SYNC0};
		cur_byte = body[{idx_q, 3'b000} +: 8];
		load     = (state_q == ST_SEND) && (!out_valid_q || !out_stall);
	end

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tick_q  <= q_entry.tick;
			first_q <= q_entry.first;
		end
		if (state_q == ST_PREP) begin
			elapsed_q  <= elapsed;
			meas_num_q <= meas_n;
			rate_num_q <= NW'({am, 1'b0}) + NW'(div_e);
			rate_den_q <= {div_e, 1'b0};
			rate_neg_q <= m[23];
			fwd_q      <= itf_pkg::round_sat16(NW'((a_s + 17'd1) >> 1), s[16]);
			turn_q     <= itf_pkg::round_sat16(NW'((a_t + 17'd1) >> 1), dt[16]);
			flags_q    <= {4'b0000, moving, comp, est_e | (elapsed != '0), gyro_v};
			accel_q    <= '0;
		end
		if (state_q == ST_MEAS && div_rsp.done && est_q) begin
			old_q <= smo_q;
		end
		if (state_q == ST_ACC_GO) begin
			acc_neg_q <= sdiff[32];
		end
		if (state_q == ST_ACC && div_rsp.done) begin
			accel_q <= itf_pkg::round_sat16(div_rsp.quo, acc_neg_q);
		end
		if (state_q == ST_RATE && div_rsp.done) begin
			rate_q <= itf_pkg::round_sat16(div_rsp.quo, rate_neg_q);
			crc_q  <= itf_pkg::CRC_INIT;
		end
		if (load) begin
			out_q <= '{frame_byte: cur_byte, frame_last: (idx_q == 5'd31)};
			if (idx_q < 5'd30) begin
				crc_q <= itf_pkg::crc_byte(crc_q, cur_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seq_q       <= '0;
			last_task_q <= itf_pkg::IDLE_RST;
			sst_q       <= '0;
			gst_q       <= '0;
			gcs_q       <= '0;
			ld_q        <= '0;
			smo_q       <= '0;
			est_q       <= 1'b0;
			lfd_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					last_task_q <= tick_q.task_id;
					ld_q        <= (elapsed != '0) ? dist_v : ld_e;
					sst_q       <= t;
					smo_q       <= smo_e;
					est_q       <= est_e;
					lfd_q       <= s;
					gcs_q       <= tick_q.gyro_count;
					gst_q       <= gst_e;
					state_q     <= (elapsed != '0) ? ST_MEAS_GO : ST_RATE_GO;
				end
				ST_MEAS_GO: state_q <= ST_MEAS;
				ST_MEAS: begin
					if (div_rsp.done) begin
						if (!est_q) begin
							// first sample after a reset loads the filter directly
							smo_q   <= meas_sat[30:0];
							est_q   <= 1'b1;
							state_q <= ST_RATE_GO;
						end else begin
							smo_q   <= filt[38:8];
							state_q <= ST_ACC_GO;
						end
					end
				end
				ST_ACC_GO: state_q <= ST_ACC;
				ST_ACC: begin
					if (div_rsp.done) begin
						state_q <= ST_RATE_GO;
					end
				end
				ST_RATE_GO: state_q <= ST_RATE;
				ST_RATE: begin
					if (div_rsp.done) begin
						idx_q   <= '0;
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (load) begin
						out_valid_q <= 1'b1;
						idx_q       <= idx_q + 5'd1;
						if (idx_q == 5'd31) begin
							seq_q   <= seq_q + 8'd1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/inertia_telemetry_framer.sv =====
// Top level of the telemetry framer: register port, front, queue and back.
// Depends on itf_pkg, itf_front, itf_queue and itf_back.
//
//   channel   direction  payload       handshake
//   in        sink       tick_t        in_valid / in_stall
//   out       source     frame_out_t   out_valid / out_stall (one frame byte per item)
//   config    sink       32-bit regs   psel / penable / pwrite, pready always high
//
// Flow: a dropped tick ends in the front. An emitted tick passes the prep
// state, up to three passes of the shared divider (speed, acceleration,
// drive rate), each begun from its own GO state, then the serializer that
// sends the 32 frame bytes.
// Reset: all control state clears at once; there is no clearing pass.
// Stalls: the two-entry queue lets the front keep taking ticks while the
// back works, and the output register holds a byte for as long as out_stall.
`timescale 1ns / 1ps
module inertia_telemetry_framer #(
	parameter int TIME_BITS   = itf_pkg::TIME_BITS_DEF,
	parameter int QUEUE_DEPTH = itf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  itf_pkg::tick_t             in_item,
	output logic                       out_valid,
	input  logic                       out_stall,
	output itf_pkg::frame_out_t        out_item,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [itf_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	itf_pkg::cfg_t     cfg_q;
	logic              cfg_wr;
	logic [2:0]        reg_idx;
	logic              push, q_full, q_valid, q_pop;
	itf_pkg::q_entry_t push_entry, q_entry;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	// Write registers on the access phase; ignore addresses past the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{interval: itf_pkg::INTERVAL_RST, timeout: itf_pkg::TIMEOUT_RST,
				comp1: itf_pkg::COMP1_RST, comp2: itf_pkg::COMP2_RST,
				idle: itf_pkg::IDLE_RST};
		end else if (cfg_wr) begin
			unique case (reg_idx)
				itf_pkg::REG_INTERVAL: cfg_q.interval <= pwdata[15:0];
				itf_pkg::REG_TIMEOUT:  cfg_q.timeout  <= pwdata[15:0];
				itf_pkg::REG_COMP1:    cfg_q.comp1    <= pwdata[7:0];
				itf_pkg::REG_COMP2:    cfg_q.comp2    <= pwdata[7:0];
				itf_pkg::REG_IDLE:     cfg_q.idle     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register; zero past the list.
	always_comb begin
		unique case (reg_idx)
			itf_pkg::REG_INTERVAL: prdata = {16'h0000, cfg_q.interval};
			itf_pkg::REG_TIMEOUT:  prdata = {16'h0000, cfg_q.timeout};
			itf_pkg::REG_COMP1:    prdata = {24'h000000, cfg_q.comp1};
			itf_pkg::REG_COMP2:    prdata = {24'h000000, cfg_q.comp2};
			itf_pkg::REG_IDLE:     prdata = {24'h000000, cfg_q.idle};
			default:               prdata = '0;
		endcase
	end

	// Front: drop ticks inside the transmit interval, queue the rest.
	itf_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.interval(cfg_q.interval), .q_full(q_full),
		.push(push), .push_entry(push_entry)
	);

	itf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_entry(push_entry), .full(q_full),
		.pop_valid(q_valid), .pop_entry(q_entry), .pop(q_pop)
	);

	// Back: compute the fields and stream the frame.
	itf_back #(.TIME_BITS(TIME_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);
endmodule

// ===== rtl/itf_checker.sv =====
// Port-level checks of the telemetry framer, bound to the top level.
// Depends on itf_pkg and inertia_telemetry_framer_defines.svh.
`timescale 1ns / 1ps
`include "inertia_telemetry_framer_defines.svh"
module itf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input itf_pkg::frame_out_t out_item,
	input logic                pready
);
	logic [4:0] cnt_q;
	logic       take;

	assign take = out_valid && !out_stall;

	// count bytes within the current frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= cnt_q + 5'd1;
		end
	end

	`ITF_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled byte changed")
	`ITF_ASSERT(a_last_pos, clk, arst_n, take |-> (out_item.frame_last == (cnt_q == 5'd31)), "last mark off frame end")
	`ITF_ASSERT(a_sync0, clk, arst_n, take && cnt_q == 5'd0 |-> out_item.frame_byte == itf_pkg::SYNC0, "frame not opened by sync")
	`ITF_ASSERT(a_sync1, clk, arst_n, take && cnt_q == 5'd1 |-> out_item.frame_byte == itf_pkg::SYNC1, "second sync byte wrong")
	`ITF_ASSERT_ALWAYS(a_ready, clk, pready, "register port not ready")
endmodule

bind inertia_telemetry_framer itf_checker u_itf_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.out_item(out_item), .pready(pready)
);

// ===== test/inertia_telemetry_framer_test.sv =====
// Testbench for the telemetry framer: drives ticks and register writes and
// checks every frame byte against a built-in predictor. Depends on itf_pkg.
`timescale 1ns / 1ps
module inertia_telemetry_framer_test;

	// Predicts the 32-byte frame of each tick the front emits and holds them in order.
	class frame_scoreboard;
		logic [15:0] interval, timeout;
		logic [7:0]  comp1, comp2, idle;
		logic [7:0]  seq_no;
		bit          primed, est_ok;
		logic [31:0] send_t, sample_t, gyro_t, gyro_seen;
		longint      prev_dist, speed_q8;
		int          prev_sum;
		logic [7:0]  prev_task;
		logic [7:0]  fr [itf_pkg::FRAME_BYTES];
		itf_pkg::frame_out_t frames_due [$];
		int          errors;

		function new();
			interval = itf_pkg::INTERVAL_RST; timeout = itf_pkg::TIMEOUT_RST;
			comp1 = itf_pkg::COMP1_RST; comp2 = itf_pkg::COMP2_RST; idle = itf_pkg::IDLE_RST;
			seq_no = 0; primed = 0; est_ok = 0;
			send_t = 0; sample_t = 0; gyro_t = 0; gyro_seen = 0;
			prev_dist = 0; speed_q8 = 0; prev_sum = 0; prev_task = itf_pkg::IDLE_RST;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				itf_pkg::REG_INTERVAL: interval = v[15:0];
				itf_pkg::REG_TIMEOUT:  timeout = v[15:0];
				itf_pkg::REG_COMP1:    comp1 = v[7:0];
				itf_pkg::REG_COMP2:    comp2 = v[7:0];
				itf_pkg::REG_IDLE:     idle = v[7:0];
				default: ;
			endcase
		endfunction

		// Divide rounding half away from zero, clamp to int16.
		function logic [15:0] round_div16(longint n, longint d);
			longint a, q;
			a = (n < 0) ? -n : n;
			q = (a * 2 + d) / (d * 2);
			if (q > 40000) q = 40000;
			q = (n < 0) ? -q : q;
			if (q > 32767) q = 32767;
			if (q < -32768) q = -32768;
			return q[15:0];
		endfunction

		function void put_word(int pos, logic [15:0] v);
			fr[pos] = v[7:0];
			fr[pos + 1] = v[15:8];
		endfunction

		function void note_tick(itf_pkg::tick_t k);
			logic [31:0] t, elapsed;
			logic [7:0]  flags;
			logic [15:0] crc, accel_f;
			longint      dist_v, dd, meas, old, spd;
			int          l, r, s;
			t = k.time_ms;
			dist_v = longint'(k.distance_16th_mm);
			l = int'(k.left_drive);
			r = int'(k.right_drive);
			flags = 0;
			accel_f = 0;
			if (!primed) begin
				primed = 1;
				send_t = t - 32'(interval);
				sample_t = t; gyro_t = t; gyro_seen = k.gyro_count;
				prev_dist = dist_v; speed_q8 = 0; est_ok = 0; prev_sum = 0;
				prev_task = idle;
			end
			// drop ticks inside the transmit interval
			if ((t - send_t) < 32'(interval)) return;
			send_t = t;
			if (k.task_id != prev_task || dist_v + 80 < prev_dist) begin
				prev_dist = dist_v; sample_t = t; speed_q8 = 0; est_ok = 0;
			end
			elapsed = t - sample_t;
			if (elapsed != 0) begin
				dd = dist_v - prev_dist;
				meas = 0;
				old = speed_q8;
				if (dd > 0) begin
					meas = (dd * 16000) / longint'(elapsed);
					if (meas > 64'sh7FFF_FFFF) meas = 64'sh7FFF_FFFF;
				end
				if (!est_ok) begin
					speed_q8 = meas;
					est_ok = 1;
				end else begin
					speed_q8 = (old * 90 + meas * 166 + 128) >>> 8;
					accel_f = round_div16((speed_q8 - old) * 1000, longint'(elapsed) * 256);
				end
				prev_dist = dist_v;
				sample_t = t;
			end
			spd = (speed_q8 + 128) >>> 8;
			if (spd > 32767) spd = 32767;
			if (est_ok) flags[1] = 1;
			if (k.gyro_count != gyro_seen) begin
				gyro_seen = k.gyro_count;
				gyro_t = t;
			end
			if ((t - gyro_t) <= 32'(timeout) && k.gyro_ok) flags[0] = 1;
			if (k.task_id == comp1 || k.task_id == comp2) flags[2] = 1;
			if (l > 10 || l < -10 || r > 10 || r < -10) flags[3] = 1;
			s = l + r;
			fr[0] = itf_pkg::SYNC0; fr[1] = itf_pkg::SYNC1;
			fr[2] = itf_pkg::VERSION; fr[3] = itf_pkg::PAYLOAD_LEN;
			fr[4] = seq_no;
			seq_no = seq_no + 8'd1;
			fr[5] = k.task_id; fr[6] = k.motion_code; fr[7] = flags;
			for (int i = 0; i < 3; i++) begin
				put_word(8 + 2 * i, flags[0] ? k.accel_xyz[16 * i +: 16] : 16'h0);
				put_word(14 + 2 * i, flags[0] ? k.attitude[16 * i +: 16] : 16'h0);
			end
			put_word(20, spd[15:0]);
			put_word(22, accel_f);
			put_word(24, round_div16(longint'(s), 2));
			put_word(26, round_div16(longint'(r) - longint'(l), 2));
			put_word(28, round_div16((longint'(s) - longint'(prev_sum)) * 50,
				(interval != 0) ? longint'(interval) : 64'sd1));
			prev_sum = s;
			crc = itf_pkg::CRC_INIT;
			for (int i = 0; i < itf_pkg::FRAME_BYTES - 2; i++) begin
				crc = crc ^ {8'h00, fr[i]};
				for (int b = 0; b < 8; b++)
					crc = crc[0] ? ((crc >> 1) ^ itf_pkg::CRC_POLY) : (crc >> 1);
			end
			fr[itf_pkg::FRAME_BYTES - 2] = crc[7:0];
			fr[itf_pkg::FRAME_BYTES - 1] = crc[15:8];
			prev_task = k.task_id;
			for (int i = 0; i < itf_pkg::FRAME_BYTES; i++)
				frames_due.push_back('{frame_byte: fr[i],
					frame_last: (i == itf_pkg::FRAME_BYTES - 1)});
		endfunction

		function void check_byte(itf_pkg::frame_out_t got);
			itf_pkg::frame_out_t want;
			if (frames_due.size() == 0) begin
				$error("unexpected frame byte %h", got.frame_byte);
				errors++;
				return;
			end
			want = frames_due.pop_front();
			if (got.frame_byte !== want.frame_byte) begin
				$error("frame_byte expected %h actual %h", want.frame_byte, got.frame_byte);
				errors++;
			end
			if (got.frame_last !== want.frame_last) begin
				$error("frame_last expected %b actual %b", want.frame_last, got.frame_last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	itf_pkg::tick_t in_item = '0;
	logic out_valid;
	logic out_stall = 1;
	itf_pkg::frame_out_t out_item;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [itf_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	frame_scoreboard sb = new();

	// stimulus state: the telemetry the source is tracking
	logic [31:0] cur_time, cur_gc;
	logic signed [31:0] cur_dist;
	logic [7:0] cur_task;
	bit no_gaps = 0;
	bit hold_req = 0;
	int idle_cycles = 0;

	inertia_telemetry_framer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// Check every byte taken from the output channel.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_byte(out_item);
	end

	// Watchdog: count cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 6000) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Receiver: random stall before each byte, or a long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1;
				repeat (700) @(posedge clk);
				hold_req = 0;
			end
			gap = no_gaps ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				out_stall <= 1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 0;
			// hold stall low until one byte goes through
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	// Wait until every predicted byte is out, then let a dropped tick settle.
	task automatic drain();
		while (sb.frames_due.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic send_tick(itf_pkg::tick_t k);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_item <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_tick(k);
	endtask

	// Build a tick from the tracked state, advancing it by the given steps.
	task automatic tick_at(logic [31:0] dt, logic signed [31:0] ddist, bit gc_step,
			logic gok, logic signed [15:0] l, logic signed [15:0] r);
		itf_pkg::tick_t k;
		cur_time = cur_time + dt;
		cur_dist = cur_dist + ddist;
		if (gc_step) cur_gc = cur_gc + 32'd1;
		k.time_ms = cur_time;
		k.task_id = cur_task;
		k.motion_code = 8'($urandom);
		k.distance_16th_mm = cur_dist;
		k.gyro_count = cur_gc;
		k.gyro_ok = gok;
		k.accel_xyz = 48'({$urandom, $urandom});
		k.attitude = 48'({$urandom, $urandom});
		k.left_drive = l;
		k.right_drive = r;
		send_tick(k);
	endtask

	task automatic random_tick();
		int unsigned iv;
		logic [31:0] dt;
		logic signed [31:0] dd;
		logic signed [15:0] l, r;
		int sel;
		iv = (sb.interval != 16'd0) ? 32'(sb.interval) : 32'd1;
		sel = $urandom_range(0, 9);
		case (sel)
			0: dt = 0;
			1, 2, 3, 4, 5: dt = 32'($urandom_range(iv, 2 * iv + 1));
			6: dt = 1;
			7, 8: dt = 32'($urandom_range(0, iv));
			default: dt = $urandom;
		endcase
		sel = $urandom_range(0, 19);
		if (sel < 15) dd = $urandom_range(0, 400);
		else if (sel < 18) dd = -$signed($urandom_range(0, 200));
		else dd = $urandom;
		// mostly keep the task so the estimate gets a chance to settle
		sel = $urandom_range(0, 19);
		case (sel)
			0: cur_task = sb.comp1;
			1: cur_task = sb.comp2;
			2: cur_task = sb.idle;
			3: cur_task = 8'($urandom);
			default: ;
		endcase
		if ($urandom_range(0, 30) == 0) cur_gc = $urandom;
		if ($urandom_range(0, 1)) begin
			l = 16'($urandom_range(0, 24) - 12);
			r = 16'($urandom_range(0, 24) - 12);
		end else begin
			l = 16'($urandom);
			r = 16'($urandom);
		end
		tick_at(dt, dd, 1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0, l, r);
	endtask

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 30 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			if (i == n / 2) hold_req = 1;
			if (i == n / 3) begin
				in_valid <= 0;
				drain();
			end
			random_tick();
		end
		in_valid <= 0;
		drain();
	endtask

	initial begin
		cur_time = 32'hFFFF_FFE0;
		cur_dist = 0;
		cur_gc = 32'h0;
		cur_task = 8'd3;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part at reset defaults.
		tick_at(0, 0, 0, 1, 0, 0);                  // first tick: takes baselines
		tick_at(5, 10, 0, 1, 0, 0);                 // inside interval: dropped
		tick_at(20, 160, 1, 1, 32767, 32767);        // full positive drive, time just before the wrap
		tick_at(20, 320, 1, 1, -32768, -32768);
		tick_at(1, 32'sh7FFF_0000, 0, 1, 32767, -32768); // large distance step, short span: dropped
		tick_at(20, 0, 0, 1, -32768, 32767);
		tick_at(20, -100, 0, 1, 11, -11);           // distance drop resets estimate
		cur_task = 8'd4;
		tick_at(20, 50, 0, 1, 10, -10);             // task change, zero elapsed
		tick_at(20, 80, 1, 0, 0, 0);                // gyro absent
		cur_task = 8'd5;
		tick_at(200, 800, 0, 1, 5, 5);              // gyro stale
		tick_at(20, 32'sh8000_0000, 1, 1, 0, 1);     // distance wraps to negative
		cur_dist = 32'sh7FFF_FFFF;
		tick_at(20, 0, 1, 1, 1, 0);
		cur_task = 8'hFF;
		tick_at(32'hFFFF_FFFF, 0, 1, 1, -1, 0);
		tick_at(20, 1000, 1, 1, 100, 300);
		tick_at(20, 1000, 1, 1, -300, -100);
		in_valid <= 0;
		drain();
		random_phase(90);

		// Settings sweep, extremes first.
		write_reg(itf_pkg::REG_INTERVAL, 32'd1);
		write_reg(itf_pkg::REG_TIMEOUT, 32'd0);
		write_reg(itf_pkg::REG_COMP1, 32'd255);
		write_reg(itf_pkg::REG_COMP2, 32'd0);
		write_reg(itf_pkg::REG_IDLE, 32'd3);
		random_phase(90);

		write_reg(itf_pkg::REG_INTERVAL, 32'd65535);
		write_reg(itf_pkg::REG_TIMEOUT, 32'd65535);
		write_reg(itf_pkg::REG_COMP1, 32'd0);
		write_reg(itf_pkg::REG_COMP2, 32'd255);
		write_reg(itf_pkg::REG_IDLE, 32'd255);
		random_phase(90);

		write_reg(itf_pkg::REG_INTERVAL, 32'd7);
		write_reg(itf_pkg::REG_TIMEOUT, 32'd50);
		write_reg(itf_pkg::REG_COMP1, 32'd9);
		write_reg(itf_pkg::REG_COMP2, 32'd9);
		random_phase(90);

		write_reg(itf_pkg::REG_INTERVAL, 32'(itf_pkg::INTERVAL_RST));
		write_reg(itf_pkg::REG_TIMEOUT, 32'(itf_pkg::TIMEOUT_RST));
		write_reg(itf_pkg::REG_COMP1, 32'(itf_pkg::COMP1_RST));
		write_reg(itf_pkg::REG_COMP2, 32'(itf_pkg::COMP2_RST));
		random_phase(90);

		if (sb.errors == 0 && sb.frames_due.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
